>>> design/assert_macros.svh
// Assertion helpers for the RTL files; the top-level overlay includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while out of reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> design/sbo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sbo_pkg;

  // Width of a pattern phase, enough for bitmap_width + gap_width.
  localparam int PH_W = 12;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  localparam logic [2:0] CFG_AREA_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_AREA_HEIGHT   = 3'd1;
  localparam logic [2:0] CFG_BITMAP_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_SCROLL_OFFSET = 3'd3;
  localparam logic [2:0] CFG_GAP_WIDTH     = 3'd4;
  localparam logic [2:0] CFG_TEXT_COLOR    = 3'd5;
  localparam logic [2:0] CFG_PIXEL_FORMAT  = 3'd6;

  localparam logic FMT_RGB565 = 1'b0;
  localparam logic FMT_BGR24  = 1'b1;

  typedef struct packed {
    logic        action;
    logic [11:0] bitmap_address;
    logic [7:0]  bitmap_byte;
    logic [7:0]  pixel_byte0;
    logic [7:0]  pixel_byte1;
    logic [7:0]  pixel_byte2;
  } in_t;

  typedef struct packed {
    logic [15:0] color;
    logic        row_end;
    logic        frame_end;
  } out_t;

  typedef struct packed {
    logic            busy;
    logic            done;
    logic [PH_W-1:0] rem_a;
    logic [PH_W-1:0] rem_b;
  } div_stat_t;

  function automatic logic [15:0] to_rgb565(input logic fmt, input logic [7:0] b0,
                                            input logic [7:0] b1, input logic [7:0] b2);
    logic [15:0] c;
    if (fmt == FMT_BGR24) begin
      c = {b2 & 8'hF8, 8'h00} | {5'd0, b1 & 8'hFC, 3'd0} | {11'd0, b0[7:3]};
    end else begin
      c = {b1, b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/sbo_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module sbo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> design/sbo_rem.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring remainder unit, one dividend bit per cycle, two dividends
// against one divisor.
module sbo_rem #(
  parameter int DIV_W = 11
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [DIV_W-1:0]            dividend_a,
  input  wire logic [DIV_W-1:0]            dividend_b,
  input  wire logic [sbo_pkg::PH_W-1:0]    divisor,
  output sbo_pkg::div_stat_t               stat
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [DIV_W-1:0]         da_r, db_r;
  logic [sbo_pkg::PH_W-1:0] ra_r, rb_r;
  logic [CW-1:0]            cnt_r;
  logic                     busy_r, done_r;

  function automatic logic [sbo_pkg::PH_W-1:0] rem_step(input logic [sbo_pkg::PH_W-1:0] r,
                                                        input logic b,
                                                        input logic [sbo_pkg::PH_W-1:0] d);
    logic [sbo_pkg::PH_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[sbo_pkg::PH_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      da_r <= dividend_a;
      db_r <= dividend_b;
      ra_r <= '0;
      rb_r <= '0;
    end else if (busy_r) begin
      ra_r <= rem_step(ra_r, da_r[DIV_W-1], divisor);
      rb_r <= rem_step(rb_r, db_r[DIV_W-1], divisor);
      da_r <= da_r << 1;
      db_r <= db_r << 1;
    end
  end

  always_comb begin
    stat.busy  = busy_r;
    stat.done  = done_r;
    stat.rem_a = ra_r;
    stat.rem_b = rb_r;
  end

endmodule

`default_nettype wire

>>> design/scrolling_bitmap_overlay.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Ports                            Beat
// input     in   in_valid/in_ready/in_data        load byte or background pixel
// result    out  out_valid/out_ready/out_data     one RGB565 pixel per pixel beat
// config    in   cfg_we/cfg_index/cfg_data        register write, no handshake
//
// One input beat per cycle while in_ready is high; an accepted pixel passes the bitmap
// store read, then the output register, before it appears on out_valid.
// A write to bitmap_width, scroll_offset or gap_width restarts the pattern phase
// remainder unit; in_ready stays low while that unit starts, runs and hands over its result.
// Reset is synchronous; the bitmap store is not cleared and needs no sweep.
// A stalled output holds its register and backs pressure to in_ready.
module scrolling_bitmap_overlay #(
  parameter int MAX_WIDTH    = 1024,
  parameter int BITMAP_BYTES = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire sbo_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output sbo_pkg::out_t      out_data,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);

  localparam int CNT_W  = $clog2(MAX_WIDTH);
  localparam int SZ_W   = CNT_W + 1;
  localparam int CMP_W  = (SZ_W > 11) ? SZ_W : 11;
  localparam int POS_W  = ((CNT_W > 10) ? CNT_W : 10) + 1;
  localparam int QW     = (POS_W > sbo_pkg::PH_W) ? POS_W : sbo_pkg::PH_W;
  localparam int ADDR_W = $clog2(BITMAP_BYTES);

  // Configuration registers.
  logic [10:0] area_width_r, area_height_r, bitmap_width_r;
  logic [10:0] scroll_r;
  logic [7:0]  gap_r;
  logic [15:0] text_color_r;
  logic        fmt_r;

  // Position state.
  logic [CNT_W-1:0]         col_r, row_r;
  logic [ADDR_W-1:0]        base_r;
  logic [sbo_pkg::PH_W-1:0] phase_r, start_phase_r;
  logic                     div_start_r;

  // Pipeline.
  logic        s1_valid_r, s1_inside_r, s1_row_end_r, s1_frame_end_r;
  logic [2:0]  s1_bit_r;
  logic [15:0] s1_bg_r;
  logic        out_valid_r;
  sbo_pkg::out_t out_data_r;

  sbo_pkg::div_stat_t div_stat;
  logic [7:0]         ram_q;

  logic              div_hold, s1_move, in_acc, pix_acc, load_acc;
  logic [CMP_W-1:0]  w_c, h_c, max_c, col_inc, row_inc;
  logic              row_end_c, frame_end_c;
  logic [POS_W:0]    scroll_ext, pos_c;
  logic              pos_neg, pos_m1;
  logic [QW-1:0]     q_c;
  logic              inside_c;
  logic [ADDR_W+QW-4:0] qbyte_ext;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W+11:0] ld_addr_ext;
  logic [ADDR_W+8:0]  bpr_ext;
  logic [8:0]        bytes_per_row;
  logic [11:0]       bw_plus7;
  logic [sbo_pkg::PH_W-1:0] period, phase_inc;

  assign div_hold = div_start_r | div_stat.busy | div_stat.done;
  assign s1_move  = s1_valid_r & (~out_valid_r | out_ready);
  assign in_ready = ~div_hold & (~s1_valid_r | s1_move);
  assign in_acc   = in_valid & in_ready;
  assign pix_acc  = in_acc & (in_data.action == sbo_pkg::ACT_PIXEL);
  assign load_acc = in_acc & (in_data.action == sbo_pkg::ACT_LOAD);

  // Clamp the area sizes to 1..MAX_WIDTH.
  function automatic logic [CMP_W-1:0] clamp_size(input logic [10:0] v,
                                                  input logic [CMP_W-1:0] mx);
    logic [CMP_W-1:0] e;
    e = {{(CMP_W-11){1'b0}}, v};
    if (e == '0) begin
      e = CMP_W'(1);
    end else if (e > mx) begin
      e = mx;
    end
    return e;
  endfunction

  always_comb begin
    max_c       = CMP_W'(MAX_WIDTH);
    w_c         = clamp_size(area_width_r, max_c);
    h_c         = clamp_size(area_height_r, max_c);
    col_inc     = {{(CMP_W-CNT_W){1'b0}}, col_r} + CMP_W'(1);
    row_inc     = {{(CMP_W-CNT_W){1'b0}}, row_r} + CMP_W'(1);
    row_end_c   = (col_inc >= w_c);
    frame_end_c = row_end_c & (row_inc >= h_c);

    scroll_ext = {{(POS_W+1-11){scroll_r[10]}}, scroll_r};
    pos_c      = {{(POS_W+1-CNT_W){1'b0}}, col_r} + scroll_ext;
    pos_neg    = pos_c[POS_W];
    pos_m1     = &pos_c;

    // With no gap the position indexes the bitmap directly; otherwise the
    // tracked phase within one bitmap-plus-gap period does.
    if (gap_r == 8'd0) begin
      q_c = {{(QW-POS_W){1'b0}}, pos_c[POS_W-1:0]};
    end else begin
      q_c = {{(QW-sbo_pkg::PH_W){1'b0}}, phase_r};
    end
    inside_c  = ~pos_neg & (q_c < {{(QW-11){1'b0}}, bitmap_width_r});
    qbyte_ext = {{ADDR_W{1'b0}}, q_c[QW-1:3]};
    rd_addr   = base_r + qbyte_ext[ADDR_W-1:0];

    ld_addr_ext   = {{ADDR_W{1'b0}}, in_data.bitmap_address};
    bw_plus7      = {1'b0, bitmap_width_r} + 12'd7;
    bytes_per_row = bw_plus7[11:3];
    bpr_ext       = {{ADDR_W{1'b0}}, bytes_per_row};

    period    = {1'b0, bitmap_width_r} + {4'd0, gap_r};
    phase_inc = phase_r + sbo_pkg::PH_W'(1);
  end

  sbo_ram #(
    .WIDTH(8),
    .DEPTH(BITMAP_BYTES)
  ) u_store (
    .clk  (clk),
    .we   (load_acc),
    .waddr(ld_addr_ext[ADDR_W-1:0]),
    .wdata(in_data.bitmap_byte),
    .re   (pix_acc),
    .raddr(rd_addr),
    .rdata(ram_q)
  );

  sbo_rem #(
    .DIV_W(POS_W)
  ) u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start_r),
    .dividend_a(pos_c[POS_W-1:0]),
    .dividend_b(scroll_ext[POS_W-1:0]),
    .divisor   (period),
    .stat      (div_stat)
  );

  // Configuration and position state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_width_r   <= 11'd1;
      area_height_r  <= 11'd1;
      bitmap_width_r <= 11'd1;
      scroll_r       <= 11'd0;
      gap_r          <= 8'd0;
      text_color_r   <= 16'hFFFF;
      fmt_r          <= sbo_pkg::FMT_RGB565;
      div_start_r    <= 1'b0;
      col_r          <= '0;
      row_r          <= '0;
      base_r         <= '0;
      phase_r        <= '0;
      start_phase_r  <= '0;
    end else begin
      div_start_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          sbo_pkg::CFG_AREA_WIDTH:    area_width_r <= cfg_data[10:0];
          sbo_pkg::CFG_AREA_HEIGHT:   area_height_r <= cfg_data[10:0];
          sbo_pkg::CFG_BITMAP_WIDTH: begin
            bitmap_width_r <= cfg_data[10:0];
            div_start_r    <= 1'b1;
          end
          sbo_pkg::CFG_SCROLL_OFFSET: begin
            scroll_r    <= cfg_data[10:0];
            div_start_r <= 1'b1;
          end
          sbo_pkg::CFG_GAP_WIDTH: begin
            gap_r       <= cfg_data[7:0];
            div_start_r <= 1'b1;
          end
          sbo_pkg::CFG_TEXT_COLOR:    text_color_r <= cfg_data;
          sbo_pkg::CFG_PIXEL_FORMAT:  fmt_r <= cfg_data[0];
          default: ;
        endcase
      end

      if (div_stat.done) begin
        phase_r       <= div_stat.rem_a;
        start_phase_r <= div_stat.rem_b;
      end else if (pix_acc) begin
        if (row_end_c) begin
          col_r   <= '0;
          phase_r <= start_phase_r;
          if (frame_end_c) begin
            row_r  <= '0;
            base_r <= '0;
          end else begin
            row_r  <= row_inc[CNT_W-1:0];
            base_r <= base_r + bpr_ext[ADDR_W-1:0];
          end
        end else begin
          col_r <= col_inc[CNT_W-1:0];
          // Position crosses from -1 to zero, or the phase reaches the period: the pattern starts fresh.
          if (pos_m1 || phase_inc == period) begin
            phase_r <= '0;
          end else begin
            phase_r <= phase_inc;
          end
        end
      end
    end
  end

  // Pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pix_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_move) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_inside_r    <= inside_c;
      s1_bit_r       <= q_c[2:0];
      s1_bg_r        <= sbo_pkg::to_rgb565(fmt_r, in_data.pixel_byte0,
                                           in_data.pixel_byte1, in_data.pixel_byte2);
      s1_row_end_r   <= row_end_c;
      s1_frame_end_r <= frame_end_c;
    end
    if (s1_move) begin
      if (s1_inside_r && ((ram_q & (8'h80 >> s1_bit_r)) != 8'h00)) begin
        out_data_r.color <= text_color_r;
      end else begin
        out_data_r.color <= s1_bg_r;
      end
      out_data_r.row_end   <= s1_row_end_r;
      out_data_r.frame_end <= s1_frame_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`include "assert_macros.svh"

  `ASSERT_CLK(a_frame_has_row_end, clk, rst_n, out_valid |-> (!out_data.frame_end || out_data.row_end))
  `ASSERT_CLK(a_scroll_holds_input, clk, rst_n, (cfg_we && cfg_index == sbo_pkg::CFG_SCROLL_OFFSET) |=> !in_ready)
  `ASSERT_CLK(a_row_end_clears_col, clk, rst_n, (pix_acc && row_end_c) |=> (col_r == '0))
  `ASSERT_ALWAYS(a_no_accept_in_remainder, clk, !(div_stat.busy && in_ready))

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sbo_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int STORE_BYTES = 4096;
  localparam int LONG_HOLD = 300;
  localparam int PRINT_CAP = 100;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #6 clk = ~clk;

  scrolling_bitmap_overlay dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  in_t pending_beats[$];
  out_t expected_pixels[$];
  int beats_queued = 0;
  int beats_taken = 0;
  int cycles = 0;
  int mismatches = 0;
  logic in_beat = 1'b0;
  int send_gap = 0;
  bit tx_idle = 1'b0;
  bit rx_idle = 1'b0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;

  // Overlay state as the block should hold it.
  logic [7:0] text_bitmap [STORE_BYTES];
  int col_now = 0;
  int row_now = 0;
  logic [11:0] row_base = '0;
  logic [10:0] area_w = 11'd1;
  logic [10:0] area_h = 11'd1;
  logic [10:0] bmp_w = 11'd1;
  logic signed [10:0] scroll = '0;
  logic [7:0] gap_w = '0;
  logic [15:0] text_rgb = 16'hFFFF;
  logic fmt = FMT_RGB565;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int clamp_area(logic [10:0] v);
    if (v == 0) return 1;
    if (v > 11'd1024) return 1024;
    return int'(v);
  endfunction

  function automatic out_t overlay_pixel(in_t px);
    out_t r;
    int w, h, pos, period;
    logic hit;
    w = clamp_area(area_w);
    h = clamp_area(area_h);
    pos = col_now + int'(scroll);
    period = int'(bmp_w) + int'(gap_w);
    hit = 1'b0;
    // A negative bitmap column always shows the background.
    if (pos >= 0) begin
      if (gap_w != 0) begin
        pos = pos % period;
      end
      if (pos < int'(bmp_w)) begin
        hit = text_bitmap[(int'(row_base) + pos / 8) % STORE_BYTES][7 - pos % 8];
      end
    end
    if (hit) begin
      r.color = text_rgb;
    end else if (fmt == FMT_BGR24) begin
      r.color = {px.pixel_byte2[7:3], px.pixel_byte1[7:2], px.pixel_byte0[7:3]};
    end else begin
      r.color = {px.pixel_byte1, px.pixel_byte0};
    end
    r.row_end = (col_now + 1 >= w);
    r.frame_end = r.row_end && (row_now + 1 >= h);
    if (r.row_end) begin
      col_now = 0;
      if (r.frame_end) begin
        row_now = 0;
        row_base = '0;
      end else begin
        row_now++;
        row_base = 12'((int'(row_base) + (int'(bmp_w) + 7) / 8) % STORE_BYTES);
      end
    end else begin
      col_now++;
    end
    return r;
  endfunction

  function automatic in_t load_beat(logic [11:0] addr, logic [7:0] value);
    in_t b;
    b.action = ACT_LOAD;
    b.bitmap_address = addr;
    b.bitmap_byte = value;
    b.pixel_byte0 = 8'($urandom);
    b.pixel_byte1 = 8'($urandom);
    b.pixel_byte2 = 8'($urandom);
    return b;
  endfunction

  function automatic in_t pixel_beat(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2);
    in_t b;
    b.action = ACT_PIXEL;
    b.bitmap_address = 12'($urandom);
    b.bitmap_byte = 8'($urandom);
    b.pixel_byte0 = b0;
    b.pixel_byte1 = b1;
    b.pixel_byte2 = b2;
    return b;
  endfunction

  function automatic int pick_size(int typical);
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 1024;
      2: return 2047;
      3: return $urandom_range(1, 1024);
      default: return $urandom_range(1, typical);
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) begin
      $display("mismatch at cycle %0d: %s", cycles, msg);
    end
  endtask

  task automatic queue_beat(in_t b);
    pending_beats.push_back(b);
    beats_queued++;
  endtask

  task automatic push_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 99) < 15) begin
        queue_beat(load_beat(12'($urandom), 8'($urandom)));
      end else begin
        queue_beat(pixel_beat(8'($urandom), 8'($urandom), 8'($urandom)));
      end
    end
  endtask

  // Returns once every beat is taken and every pixel is back, then waits on
  // so that a trailing load has left the pipeline.
  task automatic wait_drained();
    @(negedge clk);
    while (beats_taken != beats_queued || expected_pixels.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_AREA_WIDTH: area_w = data[10:0];
      CFG_AREA_HEIGHT: area_h = data[10:0];
      CFG_BITMAP_WIDTH: bmp_w = data[10:0];
      CFG_SCROLL_OFFSET: scroll = data[10:0];
      CFG_GAP_WIDTH: gap_w = data[7:0];
      CFG_TEXT_COLOR: text_rgb = data;
      CFG_PIXEL_FORMAT: fmt = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int aw, int ah, int bw, int so, int gp, int tc, int pf);
    write_reg(CFG_AREA_WIDTH, 16'(aw) & 16'h07FF);
    write_reg(CFG_AREA_HEIGHT, 16'(ah) & 16'h07FF);
    write_reg(CFG_BITMAP_WIDTH, 16'(bw) & 16'h07FF);
    write_reg(CFG_SCROLL_OFFSET, 16'(so) & 16'h07FF);
    write_reg(CFG_GAP_WIDTH, 16'(gp) & 16'h00FF);
    write_reg(CFG_TEXT_COLOR, 16'(tc));
    write_reg(CFG_PIXEL_FORMAT, 16'(pf) & 16'h0001);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin : scoreboard
    out_t want;
    in_beat <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("pixel beat %h with nothing pending", out_data));
      end else begin
        want = expected_pixels.pop_front();
        if (out_data.color !== want.color) begin
          report_mismatch($sformatf("color %h, want %h", out_data.color, want.color));
        end
        if (out_data.row_end !== want.row_end) begin
          report_mismatch($sformatf("row_end %b, want %b", out_data.row_end, want.row_end));
        end
        if (out_data.frame_end !== want.frame_end) begin
          report_mismatch($sformatf("frame_end %b, want %b",
                                    out_data.frame_end, want.frame_end));
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      beats_taken++;
      if (in_data.action == ACT_PIXEL) begin
        expected_pixels.push_back(overlay_pixel(in_data));
      end else begin
        text_bitmap[in_data.bitmap_address] = in_data.bitmap_byte;
      end
    end
  end

  always @(negedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_beat) begin
      // The offered beat stays put until it is taken.
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_beats.size() != 0) begin
      in_data <= pending_beats.pop_front();
      in_valid <= 1'b1;
      send_gap <= tx_idle ? pick_gap() : 0;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : receiver
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      stall_left <= rx_idle ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int random_count;
    int n;
    int so_v;
    int gap_v;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every store byte is loaded first so that no pixel reads an unwritten one.
    @(posedge clk);
    for (int a = 0; a < STORE_BYTES; a++) begin
      queue_beat(load_beat(12'(a), 8'($urandom)));
    end
    wait_drained();

    // Registers still at their reset values.
    @(posedge clk);
    queue_beat(load_beat(12'd0, 8'h80));
    queue_beat(pixel_beat(8'h00, 8'h00, 8'hFF));
    wait_drained();

    // Negative columns, then a clear bit in 24-bit format.
    apply_settings(3, 2, 8, -2, 0, 16'h0000, FMT_BGR24);
    @(posedge clk);
    queue_beat(load_beat(12'd0, 8'h7F));
    queue_beat(pixel_beat(8'hFF, 8'hFF, 8'hFF));
    queue_beat(pixel_beat(8'h00, 8'h00, 8'h00));
    queue_beat(pixel_beat(8'h07, 8'h03, 8'hF8));
    queue_beat(pixel_beat(8'hFF, 8'h00, 8'hFF));
    wait_drained();

    // Zero and oversized areas, widest bitmap, widest gap: one pixel per row,
    // so the row base walks through the store and wraps.
    write_reg(CFG_UNUSED, 16'($urandom));
    apply_settings(0, 2047, 2047, 1023, 255, 16'hFFFF, FMT_RGB565);
    @(posedge clk);
    repeat (17) queue_beat(pixel_beat(8'($urandom), 8'($urandom), 8'($urandom)));
    wait_drained();

    // A bitmap of width zero shows only background.
    apply_settings(1024, 1, 0, -1024, 5, 16'h5A5A, FMT_BGR24);
    @(posedge clk);
    queue_beat(pixel_beat(8'hFF, 8'hFF, 8'hFF));
    queue_beat(pixel_beat(8'h00, 8'h00, 8'h00));
    wait_drained();

    // The receiver holds off while the sender keeps offering beats.
    apply_settings(16, 4, 24, -3, 4, $urandom, $urandom_range(0, 1));
    @(posedge clk);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    push_random(120);
    hold_requests++;
    wait_drained();

    // Same settings after the sender paused for a full drain.
    @(posedge clk);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    push_random(40);
    wait_drained();

    random_count = 160;
    while (random_count < 600) begin
      case ($urandom_range(0, 9))
        0: so_v = -1024;
        1: so_v = 1023;
        2: so_v = int'($urandom_range(0, 2047)) - 1024;
        default: so_v = int'($urandom_range(0, 96)) - 48;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3: gap_v = 0;
        4: gap_v = 255;
        5: gap_v = $urandom_range(0, 255);
        default: gap_v = $urandom_range(1, 12);
      endcase
      apply_settings(pick_size(24), pick_size(6), pick_size(40), so_v, gap_v,
                     $urandom, $urandom_range(0, 1));
      @(posedge clk);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      n = $urandom_range(15, 50);
      push_random(n);
      random_count += n;
      wait_drained();
    end

    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> scrolling_bitmap_overlay.f
+incdir+design
design/sbo_pkg.sv
design/sbo_ram.sv
design/sbo_rem.sv
design/scrolling_bitmap_overlay.sv
tb/testbench.sv
